@@ rtl/ebalu_pkg.sv @@
// ----------------------------------------------------------------------------
// ebalu_pkg
// Shared operation codes, flag positions and transaction types of the
// eight-bit ALU with flags.
// ----------------------------------------------------------------------------
package ebalu_pkg;

  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_ADC    = 5'd1,
    OP_SUB    = 5'd2,
    OP_SBC    = 5'd3,
    OP_AND    = 5'd4,
    OP_XOR    = 5'd5,
    OP_OR     = 5'd6,
    OP_CP     = 5'd7,
    OP_INC    = 5'd8,
    OP_DEC    = 5'd9,
    OP_RLC    = 5'd10,
    OP_RRC    = 5'd11,
    OP_RL     = 5'd12,
    OP_RR     = 5'd13,
    OP_SLA    = 5'd14,
    OP_SRA    = 5'd15,
    OP_SRL    = 5'd16,
    OP_SWAP   = 5'd17,
    OP_BIT    = 5'd18,
    OP_SET    = 5'd19,
    OP_RES    = 5'd20,
    OP_RLCA   = 5'd21,
    OP_RRCA   = 5'd22,
    OP_RLA    = 5'd23,
    OP_RRA    = 5'd24,
    OP_CPL    = 5'd25,
    OP_CCF    = 5'd26,
    OP_SCF    = 5'd27,
    OP_HL_ADD = 5'd28,
    OP_SP_ADD = 5'd29,
    OP_LD_A   = 5'd30
  } op_e;

  typedef struct packed {
    logic [4:0]        operation;
    logic [7:0]        operand;
    logic [2:0]        bit_index;
    logic [15:0]       wide_base;
    logic [15:0]       wide_operand;
    logic signed [7:0] offset;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  result_byte;
    logic [15:0] result_wide;
    logic [3:0]  flags;
    logic [7:0]  accumulator_value;
  } out_item_t;

  typedef struct packed {
    logic [7:0] acc_next;
    logic [3:0] flags_next;
    out_item_t  item;
  } exec_res_t;

endpackage

@@ rtl/ebalu_if.sv @@
// ----------------------------------------------------------------------------
// ebalu_in_if / ebalu_out_if
// Valid/ready channels for operation and result transactions.
// ----------------------------------------------------------------------------
interface ebalu_in_if;
  logic              valid;
  logic              ready;
  logic [4:0]        operation;
  logic [7:0]        operand;
  logic [2:0]        bit_index;
  logic [15:0]       wide_base;
  logic [15:0]       wide_operand;
  logic signed [7:0] offset;

  modport source (
    output valid, operation, operand, bit_index, wide_base, wide_operand, offset,
    input  ready
  );
  modport sink (
    input  valid, operation, operand, bit_index, wide_base, wide_operand, offset,
    output ready
  );
endinterface

interface ebalu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  result_byte;
  logic [15:0] result_wide;
  logic [3:0]  flags;
  logic [7:0]  accumulator_value;

  modport source (
    output valid, result_byte, result_wide, flags, accumulator_value,
    input  ready
  );
  modport sink (
    input  valid, result_byte, result_wide, flags, accumulator_value,
    output ready
  );
endinterface

@@ rtl/ebalu_exec.sv @@
// ----------------------------------------------------------------------------
// ebalu_exec
// Single-pass execute logic: computes the result, the next accumulator and
// the next flags of one operation from the registered transaction.
// ----------------------------------------------------------------------------
module ebalu_exec (
  input  ebalu_pkg::in_item_t  item_i,
  input  logic [7:0]           acc_i,
  input  logic [3:0]           flags_i,
  output ebalu_pkg::exec_res_t res_o
);

  logic [7:0]  a;
  logic [7:0]  v;
  logic [7:0]  x;
  logic [7:0]  offs;
  logic        cin;
  logic        zf;
  logic        t;
  logic [8:0]  sum9;
  logic [4:0]  hsum;
  logic [8:0]  dif9;
  logic [4:0]  hdif;
  logic [16:0] sum17;
  logic [12:0] hsum13;
  logic [15:0] ext;
  logic [15:0] sp_sum;
  logic [4:0]  sp_h;
  logic [8:0]  sp_c;
  logic [7:0]  r;
  logic [15:0] wide;
  logic [3:0]  f;
  logic        has_byte;
  logic        write_a;

  assign a    = acc_i;
  assign v    = item_i.operand;
  assign offs = $unsigned(item_i.offset);
  assign cin  = flags_i[ebalu_pkg::FlagC];
  assign zf   = flags_i[ebalu_pkg::FlagZ];
  assign t    = ((item_i.operation == ebalu_pkg::OP_ADC) ||
                 (item_i.operation == ebalu_pkg::OP_SBC)) ? cin : 1'b0;
  assign x    = (item_i.operation >= ebalu_pkg::OP_RLCA) ? a : v;

  assign sum9   = {1'b0, a} + {1'b0, v} + {8'd0, t};
  assign hsum   = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, t};
  assign dif9   = {1'b0, a} - {1'b0, v} - {8'd0, t};
  assign hdif   = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, t};
  assign sum17  = {1'b0, item_i.wide_base} + {1'b0, item_i.wide_operand};
  assign hsum13 = {1'b0, item_i.wide_base[11:0]} + {1'b0, item_i.wide_operand[11:0]};
  assign ext    = {{8{offs[7]}}, offs};
  assign sp_sum = item_i.wide_base + ext;
  assign sp_h   = {1'b0, item_i.wide_base[3:0]} + {1'b0, offs[3:0]};
  assign sp_c   = {1'b0, item_i.wide_base[7:0]} + {1'b0, offs};

  always_comb begin
    r        = 8'd0;
    wide     = 16'd0;
    f        = flags_i;
    has_byte = 1'b1;
    write_a  = 1'b0;
    case (item_i.operation)
      ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC: begin
        r       = sum9[7:0];
        f       = {r == 8'd0, 1'b0, hsum[4], sum9[8]};
        write_a = 1'b1;
      end
      ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC: begin
        r       = dif9[7:0];
        f       = {r == 8'd0, 1'b1, hdif[4], dif9[8]};
        write_a = 1'b1;
      end
      ebalu_pkg::OP_CP: begin
        f        = {dif9[7:0] == 8'd0, 1'b1, hdif[4], dif9[8]};
        has_byte = 1'b0;
      end
      ebalu_pkg::OP_AND: begin
        r       = a & v;
        f       = {r == 8'd0, 3'b010};
        write_a = 1'b1;
      end
      ebalu_pkg::OP_XOR: begin
        r       = a ^ v;
        f       = {r == 8'd0, 3'b000};
        write_a = 1'b1;
      end
      ebalu_pkg::OP_OR: begin
        r       = a | v;
        f       = {r == 8'd0, 3'b000};
        write_a = 1'b1;
      end
      ebalu_pkg::OP_INC: begin
        r = v + 8'd1;
        f = {r == 8'd0, 1'b0, r[3:0] == 4'h0, cin};
      end
      ebalu_pkg::OP_DEC: begin
        r = v - 8'd1;
        f = {r == 8'd0, 1'b1, r[3:0] == 4'hF, cin};
      end
      ebalu_pkg::OP_RLC: begin
        r = {x[6:0], x[7]};
        f = {r == 8'd0, 2'b00, x[7]};
      end
      ebalu_pkg::OP_RRC: begin
        r = {x[0], x[7:1]};
        f = {r == 8'd0, 2'b00, x[0]};
      end
      ebalu_pkg::OP_RL: begin
        r = {x[6:0], cin};
        f = {r == 8'd0, 2'b00, x[7]};
      end
      ebalu_pkg::OP_RR: begin
        r = {cin, x[7:1]};
        f = {r == 8'd0, 2'b00, x[0]};
      end
      ebalu_pkg::OP_SLA: begin
        r = {x[6:0], 1'b0};
        f = {r == 8'd0, 2'b00, x[7]};
      end
      ebalu_pkg::OP_SRA: begin
        r = {x[7], x[7:1]};
        f = {r == 8'd0, 2'b00, x[0]};
      end
      ebalu_pkg::OP_SRL: begin
        r = {1'b0, x[7:1]};
        f = {r == 8'd0, 2'b00, x[0]};
      end
      ebalu_pkg::OP_SWAP: begin
        r = {v[3:0], v[7:4]};
        f = {r == 8'd0, 3'b000};
      end
      ebalu_pkg::OP_BIT: begin
        f        = {~v[item_i.bit_index], 2'b01, cin};
        has_byte = 1'b0;
      end
      ebalu_pkg::OP_SET: r = v | (8'd1 << item_i.bit_index);
      ebalu_pkg::OP_RES: r = v & ~(8'd1 << item_i.bit_index);
      ebalu_pkg::OP_RLCA: begin
        r       = {x[6:0], x[7]};
        f       = {3'b000, x[7]};
        write_a = 1'b1;
      end
      ebalu_pkg::OP_RRCA: begin
        r       = {x[0], x[7:1]};
        f       = {3'b000, x[0]};
        write_a = 1'b1;
      end
      ebalu_pkg::OP_RLA: begin
        r       = {x[6:0], cin};
        f       = {3'b000, x[7]};
        write_a = 1'b1;
      end
      ebalu_pkg::OP_RRA: begin
        r       = {cin, x[7:1]};
        f       = {3'b000, x[0]};
        write_a = 1'b1;
      end
      ebalu_pkg::OP_CPL: begin
        r       = ~a;
        f       = {zf, 2'b11, cin};
        write_a = 1'b1;
      end
      ebalu_pkg::OP_CCF: begin
        f        = {zf, 2'b00, ~cin};
        has_byte = 1'b0;
      end
      ebalu_pkg::OP_SCF: begin
        f        = {zf, 3'b001};
        has_byte = 1'b0;
      end
      ebalu_pkg::OP_HL_ADD: begin
        wide     = sum17[15:0];
        f        = {zf, 1'b0, hsum13[12], sum17[16]};
        has_byte = 1'b0;
      end
      ebalu_pkg::OP_SP_ADD: begin
        wide     = sp_sum;
        f        = {2'b00, sp_h[4], sp_c[8]};
        has_byte = 1'b0;
      end
      ebalu_pkg::OP_LD_A: begin
        r       = v;
        write_a = 1'b1;
      end
      default: has_byte = 1'b0;
    endcase
  end

  always_comb begin
    res_o.acc_next                = write_a ? r : a;
    res_o.flags_next              = f;
    res_o.item.result_byte        = has_byte ? r : res_o.acc_next;
    res_o.item.result_wide        = wide;
    res_o.item.flags              = f;
    res_o.item.accumulator_value  = res_o.acc_next;
  end

endmodule

@@ rtl/eight_bit_alu_with_flags_unit.sv @@
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_unit
// Accumulator and Z/N/H/C flags of an 8-bit CPU with its execute unit.
//
// Usage:
// - in_i carries one operation per transaction (operation code, operand,
//   bit index, 16-bit base and operand, signed SP offset).
// - out_o returns exactly one result transaction per operation: result
//   byte, 16-bit result, flags and the accumulator after the operation.
// - An accepted operation passes through the input register, where it is
//   executed, and then the result register before it is valid on out_o;
//   the result register takes it only while out_o is free.
// - Throughput is one transaction per cycle while out_o is not stalled;
//   the accumulator and flags are written as an operation leaves the
//   input register, so the next one sees them without a bubble.
// - A stalled out_o holds its result; the input register then still takes
//   one more transaction, and in_i.ready drops only when both are full.
// - Reset clears the accumulator, the flags and both valid bits.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  ebalu_in_if.sink     in_i,
  ebalu_out_if.source  out_o
);

  logic                  s1_valid_q;
  ebalu_pkg::in_item_t   s1_q;
  logic                  out_valid_q;
  ebalu_pkg::out_item_t  out_q;
  logic [7:0]            acc_q;
  logic [3:0]            flags_q;
  logic                  out_free;
  logic                  s1_adv;
  logic                  in_take;
  ebalu_pkg::in_item_t   in_item;
  ebalu_pkg::exec_res_t  exec_res;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_take  = in_i.valid && in_i.ready;

  always_comb begin
    in_item.operation    = in_i.operation;
    in_item.operand      = in_i.operand;
    in_item.bit_index    = in_i.bit_index;
    in_item.wide_base    = in_i.wide_base;
    in_item.wide_operand = in_i.wide_operand;
    in_item.offset       = in_i.offset;
  end

  ebalu_exec u_exec (
    .item_i  (s1_q),
    .acc_i   (acc_q),
    .flags_i (flags_q),
    .res_o   (exec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= 8'd0;
      flags_q     <= 4'd0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        acc_q   <= exec_res.acc_next;
        flags_q <= exec_res.flags_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_item;
    end
    if (s1_adv) begin
      out_q <= exec_res.item;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.result_byte       = out_q.result_byte;
  assign out_o.result_wide       = out_q.result_wide;
  assign out_o.flags             = out_q.flags;
  assign out_o.accumulator_value = out_q.accumulator_value;

  a_acc_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (out_q.accumulator_value == acc_q))
    else $error("result accumulator differs from held accumulator");

  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (out_q.flags == flags_q))
    else $error("result flags differ from held flags");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> ($stable(acc_q) && $stable(flags_q)))
    else $error("state changed without an operation leaving the input register");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free register");

  a_wide_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (s1_q.operation != ebalu_pkg::OP_HL_ADD) &&
     (s1_q.operation != ebalu_pkg::OP_SP_ADD)) |=> (out_q.result_wide == 16'd0))
    else $error("16-bit result set by an 8-bit operation");

endmodule

@@ tb/tb_eight_bit_alu_with_flags_unit.sv @@
// ----------------------------------------------------------------------------
// tb_eight_bit_alu_with_flags_unit
// Self-checking bench for the eight-bit ALU with flags. A directed table covers
// every operation code, the unused code and the operand extremes, and a few
// rows after reset carry hand-computed results. Random operations follow.
// The other results are checked field by field against an in-bench model
// of the accumulator and flags. Both channels idle at random, with one long
// stretch of no idling and one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_eight_bit_alu_with_flags_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0] OpUnused = 5'd31;
  localparam int unsigned DirRows = 35;
  localparam int unsigned RandOps = 1350;
  localparam int unsigned HoldCycles = 48;

  typedef struct packed {
    ebalu_pkg::in_item_t  stim;
    logic                 typed;
    ebalu_pkg::out_item_t want;
  } dir_row_t;

  localparam ebalu_pkg::out_item_t NoWant = '0;

  localparam dir_row_t DirTab [DirRows] = '{
    '{'{ebalu_pkg::OP_CP,     8'h00, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b1,
      '{8'h00, 16'h0000, 4'hC, 8'h00}},
    '{'{ebalu_pkg::OP_LD_A,   8'hFF, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b1,
      '{8'hFF, 16'h0000, 4'hC, 8'hFF}},
    '{'{ebalu_pkg::OP_ADD,    8'h01, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b1,
      '{8'h00, 16'h0000, 4'hB, 8'h00}},
    '{'{ebalu_pkg::OP_ADC,    8'hFF, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b1,
      '{8'h00, 16'h0000, 4'hB, 8'h00}},
    '{'{ebalu_pkg::OP_SBC,    8'h00, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b1,
      '{8'hFF, 16'h0000, 4'h7, 8'hFF}},
    '{'{ebalu_pkg::OP_SUB,    8'hFF, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b1,
      '{8'h00, 16'h0000, 4'hC, 8'h00}},
    '{'{ebalu_pkg::OP_LD_A,   8'h5A, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_AND,    8'h0F, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_XOR,    8'hFF, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_OR,     8'h80, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_INC,    8'hFF, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_DEC,    8'h00, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_DEC,    8'h10, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_RLC,    8'h80, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_RRC,    8'h01, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_RL,     8'h80, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_RR,     8'h01, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_SLA,    8'h80, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_SRA,    8'h81, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_SRL,    8'h01, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_SWAP,   8'hF0, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_BIT,    8'h80, 3'd7, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_BIT,    8'hFE, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_SET,    8'h00, 3'd7, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_RES,    8'hFF, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_RLCA,   8'h00, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_RRCA,   8'h00, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_RLA,    8'h00, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_RRA,    8'h00, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_CPL,    8'h00, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_CCF,    8'h00, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_SCF,    8'h00, 3'd0, 16'h0000, 16'h0000, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_HL_ADD, 8'h00, 3'd0, 16'hFFFF, 16'h0001, 8'sh00}, 1'b0, NoWant},
    '{'{ebalu_pkg::OP_SP_ADD, 8'h00, 3'd0, 16'h00FF, 16'h0000, 8'sh80}, 1'b0, NoWant},
    '{'{OpUnused,             8'hFF, 3'd7, 16'hFFFF, 16'hFFFF, 8'sh7F}, 1'b0, NoWant}
  };

  logic clk;
  logic rst_n;

  ebalu_in_if  in_if ();
  ebalu_out_if out_if ();

  eight_bit_alu_with_flags_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [7:0] acc_model = '0;
  logic [3:0] flags_model = '0;
  ebalu_pkg::out_item_t pending_results [$];

  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned ops_sent = 0;
  bit          idle_en = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [3:0] make_flags(logic z, logic n, logic h, logic c);
    logic [3:0] f;
    f = '0;
    f[ebalu_pkg::FlagZ] = z;
    f[ebalu_pkg::FlagN] = n;
    f[ebalu_pkg::FlagH] = h;
    f[ebalu_pkg::FlagC] = c;
    return f;
  endfunction

  // Execute one operation on the model accumulator and flags.
  function automatic ebalu_pkg::out_item_t execute_op(ebalu_pkg::in_item_t it);
    logic [7:0]  a, v, r, x, off;
    logic [3:0]  f;
    logic        cin, t, co, has_byte, write_a, shift_op, acc_shift;
    logic [4:0]  nib;
    logic [8:0]  sum9, sub9;
    logic [12:0] sum13;
    logic [16:0] sum17;
    logic [15:0] wide, ext;
    ebalu_pkg::out_item_t o;
    a = acc_model;
    v = it.operand;
    off = it.offset;
    f = flags_model;
    cin = flags_model[ebalu_pkg::FlagC];
    r = '0;
    co = 1'b0;
    wide = '0;
    has_byte = 1'b1;
    write_a = 1'b0;
    shift_op = 1'b0;
    acc_shift = it.operation inside {ebalu_pkg::OP_RLCA, ebalu_pkg::OP_RRCA,
                                     ebalu_pkg::OP_RLA, ebalu_pkg::OP_RRA};
    x = acc_shift ? a : v;
    case (it.operation)
      ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC: begin
        t = (it.operation == ebalu_pkg::OP_ADC) ? cin : 1'b0;
        sum9 = a + v + t;
        nib = a[3:0] + v[3:0] + t;
        r = sum9[7:0];
        f = make_flags(r == 8'h00, 1'b0, nib[4], sum9[8]);
        write_a = 1'b1;
      end
      ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC, ebalu_pkg::OP_CP: begin
        t = (it.operation == ebalu_pkg::OP_SBC) ? cin : 1'b0;
        r = a - v - t;
        nib = v[3:0] + t;
        sub9 = v + t;
        f = make_flags(r == 8'h00, 1'b1, {1'b0, a[3:0]} < nib, {1'b0, a} < sub9);
        if (it.operation == ebalu_pkg::OP_CP) has_byte = 1'b0;
        else write_a = 1'b1;
      end
      ebalu_pkg::OP_AND: begin
        r = a & v;
        f = make_flags(r == 8'h00, 1'b0, 1'b1, 1'b0);
        write_a = 1'b1;
      end
      ebalu_pkg::OP_XOR: begin
        r = a ^ v;
        f = make_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
        write_a = 1'b1;
      end
      ebalu_pkg::OP_OR: begin
        r = a | v;
        f = make_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
        write_a = 1'b1;
      end
      ebalu_pkg::OP_INC: begin
        r = v + 8'h01;
        f = make_flags(r == 8'h00, 1'b0, r[3:0] == 4'h0, cin);
      end
      ebalu_pkg::OP_DEC: begin
        r = v - 8'h01;
        f = make_flags(r == 8'h00, 1'b1, r[3:0] == 4'hF, cin);
      end
      ebalu_pkg::OP_RLC, ebalu_pkg::OP_RLCA: begin
        co = x[7]; r = {x[6:0], x[7]}; shift_op = 1'b1;
      end
      ebalu_pkg::OP_RRC, ebalu_pkg::OP_RRCA: begin
        co = x[0]; r = {x[0], x[7:1]}; shift_op = 1'b1;
      end
      ebalu_pkg::OP_RL, ebalu_pkg::OP_RLA: begin
        co = x[7]; r = {x[6:0], cin}; shift_op = 1'b1;
      end
      ebalu_pkg::OP_RR, ebalu_pkg::OP_RRA: begin
        co = x[0]; r = {cin, x[7:1]}; shift_op = 1'b1;
      end
      ebalu_pkg::OP_SLA: begin
        co = x[7]; r = {x[6:0], 1'b0}; shift_op = 1'b1;
      end
      ebalu_pkg::OP_SRA: begin
        co = x[0]; r = {x[7], x[7:1]}; shift_op = 1'b1;
      end
      ebalu_pkg::OP_SRL: begin
        co = x[0]; r = {1'b0, x[7:1]}; shift_op = 1'b1;
      end
      ebalu_pkg::OP_SWAP: begin
        r = {v[3:0], v[7:4]};
        f = make_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      ebalu_pkg::OP_BIT: begin
        f = make_flags(!v[it.bit_index], 1'b0, 1'b1, cin);
        has_byte = 1'b0;
      end
      ebalu_pkg::OP_SET: r = v | (8'h01 << it.bit_index);
      ebalu_pkg::OP_RES: r = v & ~(8'h01 << it.bit_index);
      ebalu_pkg::OP_CPL: begin
        r = ~a;
        f = make_flags(flags_model[ebalu_pkg::FlagZ], 1'b1, 1'b1, cin);
        write_a = 1'b1;
      end
      ebalu_pkg::OP_CCF: begin
        f = make_flags(flags_model[ebalu_pkg::FlagZ], 1'b0, 1'b0, !cin);
        has_byte = 1'b0;
      end
      ebalu_pkg::OP_SCF: begin
        f = make_flags(flags_model[ebalu_pkg::FlagZ], 1'b0, 1'b0, 1'b1);
        has_byte = 1'b0;
      end
      ebalu_pkg::OP_HL_ADD: begin
        sum17 = it.wide_base + it.wide_operand;
        sum13 = it.wide_base[11:0] + it.wide_operand[11:0];
        wide = sum17[15:0];
        f = make_flags(flags_model[ebalu_pkg::FlagZ], 1'b0, sum13[12], sum17[16]);
        has_byte = 1'b0;
      end
      ebalu_pkg::OP_SP_ADD: begin
        ext = {{8{off[7]}}, off};
        wide = it.wide_base + ext;
        nib = it.wide_base[3:0] + off[3:0];
        sum9 = it.wide_base[7:0] + off;
        f = make_flags(1'b0, 1'b0, nib[4], sum9[8]);
        has_byte = 1'b0;
      end
      ebalu_pkg::OP_LD_A: begin
        r = v;
        write_a = 1'b1;
      end
      default: has_byte = 1'b0;
    endcase
    if (shift_op) begin
      f = make_flags(!acc_shift && r == 8'h00, 1'b0, 1'b0, co);
      write_a = acc_shift;
    end
    if (write_a) acc_model = r;
    flags_model = f;
    if (!has_byte) r = acc_model;
    o.result_byte = r;
    o.result_wide = wide;
    o.flags = flags_model;
    o.accumulator_value = acc_model;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("ERROR %0t: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one transaction, hold it until accepted, then log its expected result.
  task automatic issue_op(ebalu_pkg::in_item_t it, logic typed,
                          ebalu_pkg::out_item_t want);
    ebalu_pkg::out_item_t model_res;
    while (idle_en && $urandom_range(99) < 29) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= it.operation;
    in_if.operand      <= it.operand;
    in_if.bit_index    <= it.bit_index;
    in_if.wide_base    <= it.wide_base;
    in_if.wide_operand <= it.wide_operand;
    in_if.offset       <= it.offset;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    model_res = execute_op(it);
    pending_results.push_back(typed ? want : model_res);
    ops_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(7) != 0) return 8'($urandom_range(255));
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return 8'h7F;
    endcase
  endfunction

  function automatic logic [15:0] rand_word();
    if ($urandom_range(7) != 0) return 16'($urandom_range(65535));
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0FFF;
      default: return 16'h8000;
    endcase
  endfunction

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_en && $urandom_range(99) < 29);
      end
    end
  end

  always @(posedge clk) begin
    ebalu_pkg::out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result byte", 16'(out_if.result_byte), 16'h0000);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_if.result_byte !== want.result_byte)
          report_mismatch("result_byte", 16'(out_if.result_byte), 16'(want.result_byte));
        if (out_if.result_wide !== want.result_wide)
          report_mismatch("result_wide", out_if.result_wide, want.result_wide);
        if (out_if.flags !== want.flags)
          report_mismatch("flags", 16'(out_if.flags), 16'(want.flags));
        if (out_if.accumulator_value !== want.accumulator_value)
          report_mismatch("accumulator_value", 16'(out_if.accumulator_value),
                          16'(want.accumulator_value));
      end
    end
  end

  initial begin
    ebalu_pkg::in_item_t it;
    int unsigned wait_cycles;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = '0;
    in_if.operand = '0;
    in_if.bit_index = '0;
    in_if.wide_base = '0;
    in_if.wide_operand = '0;
    in_if.offset = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DirRows; i++) begin
      issue_op(DirTab[i].stim, DirTab[i].typed, DirTab[i].want);
    end

    for (int i = 0; i < RandOps; i++) begin
      idle_en = !(i >= 400 && i < 700);
      if (i == 900) hold_request = 1'b1;
      it.operation    = 5'($urandom_range(31));
      it.operand      = rand_byte();
      it.bit_index    = 3'($urandom_range(7));
      it.wide_base    = rand_word();
      it.wide_operand = rand_word();
      it.offset       = rand_byte();
      issue_op(it, 1'b0, NoWant);
    end
    in_if.valid <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch("results still pending", 16'(pending_results.size()), 16'h0000);
    end
    repeat (10) @(posedge clk);

    $display("Ran %0d operations: %0d table rows over every code, %0d random.",
             ops_sent, DirRows, RandOps);
    $display("Checked %0d results with idle gaps, a no-idle stretch and one output stall.",
             results_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ebalu_pkg.sv
rtl/ebalu_if.sv
rtl/ebalu_exec.sv
rtl/eight_bit_alu_with_flags_unit.sv
tb/tb_eight_bit_alu_with_flags_unit.sv
